// ----- rtl/core/tclc_pkg.sv -----
package tclc_pkg;

   localparam int unsigned COUNT_W = 16;
   localparam int unsigned LUX_W = 19;
   localparam int unsigned COEF_W = 20;
   localparam int unsigned ROM_W = 16;
   localparam int unsigned PROD_W = 52;
   localparam int unsigned Q_POINT = 40;

   localparam int unsigned LUX_FRAC_BITS_DEF = 8;
   localparam int unsigned POWER_TABLE_DEPTH_DEF = 64;

   localparam logic [LUX_W-1:0] LUX_MAX = 19'd524287;
   localparam logic [LUX_W-1:0] THRESHOLD_RESET = 19'd12800;

   // Segment weights, unsigned Q24.
   localparam logic [COEF_W-1:0] K_A1 = 20'd510027;
   localparam logic [COEF_W-1:0] K_B1 = 20'd1040187;
   localparam logic [COEF_W-1:0] K_A2 = 20'd375810;
   localparam logic [COEF_W-1:0] K_B2 = 20'd520094;
   localparam logic [COEF_W-1:0] K_A3 = 20'd214748;
   localparam logic [COEF_W-1:0] K_B3 = 20'd256691;
   localparam logic [COEF_W-1:0] K_A4 = 20'd24495;
   localparam logic [COEF_W-1:0] K_B4 = 20'd18790;

   typedef struct packed {
      logic [COUNT_W-1:0] ch0;
      logic [COUNT_W-1:0] ch1;
      logic [COEF_W-1:0]  coef_a;
      logic [COEF_W-1:0]  coef_b;
      logic               seg1;
   } tclc_tag_type;

   // Given r in Q30, returns r^1.4 in Q16, with r^0.4 taken as the largest
   // Q12 value whose fifth power does not exceed r squared.
   function automatic logic [ROM_W-1:0] power_entry(input logic [63:0] r30);
      logic [63:0] s60;
      logic [63:0] z;
      logic [63:0] t;
      logic [63:0] p;
      logic [63:0] prod;
      s60 = r30 * r30;
      z = 64'd0;
      for (int b = 11; b >= 0; b--) begin
         t = z | (64'd1 << b);
         p = t * t * t * t * t;
         if (p <= s60) begin
            z = t;
         end
      end
      prod = (r30 * z) >> 26;
      return prod[ROM_W-1:0];
   endfunction

endpackage

// ----- rtl/core/two_channel_lux_calculator.sv -----
// An accepted transaction passes the stage 1 register, the divider stages, the table
// read, multiply, clamp and result registers on its way to its rsp_valid strobe.
// Throughput: one transaction per cycle; busy stays low and the pipeline never stalls.
// The table index divider takes one pipeline stage per quotient bit.
// Reset clears all valid bits and sets threshold_ff to 12800.
// The receiver cannot stall: each result appears for exactly one cycle.
module two_channel_lux_calculator #(
   parameter int unsigned LUX_FRAC_BITS = tclc_pkg::LUX_FRAC_BITS_DEF,
   parameter int unsigned POWER_TABLE_DEPTH = tclc_pkg::POWER_TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tclc_pkg::COUNT_W-1:0]   req_broadband_count,
   input  logic [tclc_pkg::COUNT_W-1:0]   req_infrared_count,
   output logic                           rsp_valid,
   output logic [tclc_pkg::LUX_W-1:0]     rsp_lux_fixed,
   output logic                           rsp_is_light,
   input  logic                           csr_write_enable,
   input  logic [tclc_pkg::LUX_W-1:0]     csr_write_data
);

   import tclc_pkg::*;

   localparam int unsigned DEPTH = POWER_TABLE_DEPTH;
   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned NUM_W = 18 + IDX_W;
   localparam int unsigned DEN_W = COUNT_W + 1;
   localparam int unsigned TAG_W = $bits(tclc_tag_type);
   localparam int unsigned SHIFT = Q_POINT - LUX_FRAC_BITS;
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DEPTH - 1);
   localparam logic [NUM_W-1:0] NUM_SCALE = NUM_W'(4 * (DEPTH - 1));

   logic [ROM_W-1:0] power_rom [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_rom
      localparam logic [63:0] R30 = (64'(k) << 29) / 64'(DEPTH - 1);
      assign power_rom[k] = power_entry(R30);
   end

   logic [LUX_W-1:0] threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   assign busy = 1'b0;

   // Stage 1: segment choice by exact cross products, divider operands.
   logic             accept;
   logic [22:0]      ir_x100;
   logic [22:0]      bb_x61;
   logic [19:0]      ir_x5;
   logic [19:0]      bb_x4;
   logic [19:0]      ir_x10;
   logic [19:0]      bb_x13;
   tclc_tag_type     tag_in;
   logic [NUM_W-1:0] num_in;
   logic [DEN_W-1:0] den_in;

   logic             s1_valid_ff;
   tclc_tag_type     s1_tag_ff;
   logic [NUM_W-1:0] s1_num_ff;
   logic [DEN_W-1:0] s1_den_ff;

   assign accept = start && !busy;

   always_comb begin
      ir_x100 = 23'(req_infrared_count) * 23'd100;
      bb_x61 = 23'(req_broadband_count) * 23'd61;
      ir_x5 = 20'(req_infrared_count) * 20'd5;
      bb_x4 = 20'(req_broadband_count) * 20'd4;
      ir_x10 = 20'(req_infrared_count) * 20'd10;
      bb_x13 = 20'(req_broadband_count) * 20'd13;
      tag_in.ch0 = req_broadband_count;
      tag_in.ch1 = req_infrared_count;
      tag_in.coef_a = '0;
      tag_in.coef_b = '0;
      tag_in.seg1 = 1'b0;
      priority if (req_broadband_count == '0) begin
         tag_in.seg1 = 1'b0;
      end else if ({req_infrared_count, 1'b0} <= {1'b0, req_broadband_count}) begin
         tag_in.coef_a = K_A1;
         tag_in.coef_b = K_B1;
         tag_in.seg1 = 1'b1;
      end else if (ir_x100 <= bb_x61) begin
         tag_in.coef_a = K_A2;
         tag_in.coef_b = K_B2;
      end else if (ir_x5 <= bb_x4) begin
         tag_in.coef_a = K_A3;
         tag_in.coef_b = K_B3;
      end else if (ir_x10 <= bb_x13) begin
         tag_in.coef_a = K_A4;
         tag_in.coef_b = K_B4;
      end else begin
         tag_in.seg1 = 1'b0;
      end
      num_in = NUM_W'(req_infrared_count) * NUM_SCALE + NUM_W'(req_broadband_count);
      den_in = {req_broadband_count, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_tag_ff <= tag_in;
      s1_num_ff <= num_in;
      s1_den_ff <= den_in;
   end

   // Rounded table index: (4(D-1)ch1 + ch0) / (2ch0).
   logic             div_valid;
   logic [IDX_W-1:0] div_quot;
   logic [TAG_W-1:0] div_tag_bits;
   tclc_tag_type     div_tag;

   tclc_index_div #(
      .QW(IDX_W),
      .NW(NUM_W),
      .DW(DEN_W),
      .TW(TAG_W)
   ) u_index_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid_ff),
      .in_dividend  (s1_num_ff),
      .in_divisor   (s1_den_ff),
      .in_tag       (s1_tag_ff),
      .out_valid    (div_valid),
      .out_quotient (div_quot),
      .out_tag      (div_tag_bits)
   );

   assign div_tag = tclc_tag_type'(div_tag_bits);

   // Table read.
   logic [IDX_W-1:0] idx_in;
   logic             rd_valid_ff;
   tclc_tag_type     rd_tag_ff;
   logic [ROM_W-1:0] rd_power_ff;

   assign idx_in = (div_quot > IDX_MAX) ? IDX_MAX : div_quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= div_valid;
      end
      rd_tag_ff <= div_tag;
      rd_power_ff <= power_rom[idx_in];
   end

   // First multiply: positive term and the base of the negative term.
   logic [35:0]  pos_base_in;
   logic [31:0]  neg_base_in;
   logic         m1_valid_ff;
   logic [35:0]  m1_pos_ff;
   logic [31:0]  m1_neg_ff;
   logic [COEF_W-1:0] m1_coef_b_ff;

   always_comb begin
      pos_base_in = 36'(rd_tag_ff.coef_a) * 36'(rd_tag_ff.ch0);
      if (rd_tag_ff.seg1) begin
         neg_base_in = 32'(rd_tag_ff.ch0) * 32'(rd_power_ff);
      end else begin
         neg_base_in = {rd_tag_ff.ch1, 16'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= rd_valid_ff;
      end
      m1_pos_ff <= pos_base_in;
      m1_neg_ff <= neg_base_in;
      m1_coef_b_ff <= rd_tag_ff.coef_b;
   end

   // Second multiply: both terms in Q40.
   logic [PROD_W-1:0] neg_in;
   logic              m2_valid_ff;
   logic [PROD_W-1:0] m2_pos_ff;
   logic [PROD_W-1:0] m2_neg_ff;

   assign neg_in = PROD_W'(m1_coef_b_ff) * PROD_W'(m1_neg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else begin
         m2_valid_ff <= m1_valid_ff;
      end
      m2_pos_ff <= {m1_pos_ff, 16'd0};
      m2_neg_ff <= neg_in;
   end

   // Difference, clamp at zero, scale and saturate.
   logic [PROD_W-1:0] diff_in;
   logic [PROD_W-1:0] scaled_in;
   logic [LUX_W-1:0]  lux_in;
   logic              lx_valid_ff;
   logic [LUX_W-1:0]  lx_lux_ff;

   always_comb begin
      diff_in = m2_pos_ff - m2_neg_ff;
      scaled_in = diff_in >> SHIFT;
      if (m2_pos_ff <= m2_neg_ff) begin
         lux_in = '0;
      end else if (scaled_in > PROD_W'(LUX_MAX)) begin
         lux_in = LUX_MAX;
      end else begin
         lux_in = scaled_in[LUX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lx_valid_ff <= 1'b0;
      end else begin
         lx_valid_ff <= m2_valid_ff;
      end
      lx_lux_ff <= lux_in;
   end

   // Threshold compare and result registers.
   logic             out_valid_ff;
   logic [LUX_W-1:0] out_lux_ff;
   logic             out_light_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= lx_valid_ff;
      end
      out_lux_ff <= lx_lux_ff;
      out_light_ff <= (lx_lux_ff > threshold_ff);
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_lux_fixed = out_lux_ff;
   assign rsp_is_light = out_light_ff;

endmodule

// ----- rtl/core/tclc_index_div.sv -----
module tclc_index_div #(
   parameter int unsigned QW = 6,
   parameter int unsigned NW = 24,
   parameter int unsigned DW = 17,
   parameter int unsigned TW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_dividend,
   input  logic [DW-1:0] in_divisor,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [QW-1:0] out_quotient,
   output logic [TW-1:0] out_tag
);

   // One quotient bit per stage, most significant first.
   logic          valid_ff [QW];
   logic [NW-1:0] rem_ff   [QW];
   logic [QW-1:0] quot_ff  [QW];
   logic [DW-1:0] div_ff   [QW];
   logic [TW-1:0] tag_ff   [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int unsigned BIT = QW - 1 - s;
      logic          valid_prev;
      logic [NW-1:0] rem_prev;
      logic [QW-1:0] quot_prev;
      logic [DW-1:0] div_prev;
      logic [TW-1:0] tag_prev;
      logic [NW-1:0] div_shift;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quot_in;

      if (s == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev = in_dividend;
         assign quot_prev = '0;
         assign div_prev = in_divisor;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign rem_prev = rem_ff[s-1];
         assign quot_prev = quot_ff[s-1];
         assign div_prev = div_ff[s-1];
         assign tag_prev = tag_ff[s-1];
      end

      always_comb begin
         div_shift = NW'(div_prev) << BIT;
         if (rem_prev >= div_shift) begin
            rem_in = rem_prev - div_shift;
            quot_in = quot_prev | (QW'(1) << BIT);
         end else begin
            rem_in = rem_prev;
            quot_in = quot_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_prev;
         end
         rem_ff[s] <= rem_in;
         quot_ff[s] <= quot_in;
         div_ff[s] <= div_prev;
         tag_ff[s] <= tag_prev;
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quotient = quot_ff[QW-1];
   assign out_tag = tag_ff[QW-1];

endmodule
